[hw/rtl/sil_pkg.sv]
// shared types and codes for the shifting insert/erase list
package sil_pkg;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_ERASE      = 3'd1,
    MODE_READ       = 3'd2,
    MODE_PUSH_BACK  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_PUSH_FRONT = 3'd5,
    MODE_POP_FRONT  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_INDEX = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } sil_cmd_t;

endpackage

[hw/rtl/sil_if.sv]
// handshake channels for list operations and their results
interface sil_in_if import sil_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface sil_out_if import sil_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        count;
  logic                    is_empty;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, read_value, count, is_empty, status, input ready);
  modport sink   (input valid, read_value, count, is_empty, status, output ready);
endinterface

[hw/rtl/sil_ctrl.sv]
// controller: sequences capture, execute and the result beat
module sil_ctrl import sil_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sil_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
  a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("executed item produced no result");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC) && !in_ready)
    else $error("second item taken while one is in flight");
  a_no_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");
`endif

endmodule

[hw/rtl/sil_dpath.sv]
// datapath: row of slot registers with neighbor shifting, count and result registers
module sil_dpath import sil_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sil_cmd_t                cmd,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [CNT_W-1:0]        out_count,
  output logic                    out_is_empty,
  output logic [STATUS_W-1:0]     out_status
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  mode_t              mode_r;
  logic [POS_W-1:0]   pos_r;
  logic [VAL_W-1:0]   val_r;
  logic [VAL_W-1:0]   slots_r [DEPTH];
  logic [VAL_W-1:0]   slots_nxt [DEPTH];
  logic [VAL_W-1:0]   lo_nb [DEPTH];
  logic [VAL_W-1:0]   up_nb [DEPTH];
  logic [CW-1:0]      count_r, count_nxt;

  logic signed [VAL_W-1:0] read_value_r;
  logic [CNT_W-1:0]        count_out_r;
  logic                    is_empty_r;
  status_t                 status_r;

  logic [CMPW-1:0] pos_x, cnt_x, cnt_last, ins_idx, era_idx;
  logic            full, empty, do_ins, do_era, rd_ok;
  status_t         st;
  logic [VAL_W-1:0] rd_data;

  // item capture, payload only
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      pos_r  <= in_position;
      val_r  <= in_value;
    end
  end

  assign pos_x    = CMPW'(pos_r);
  assign cnt_x    = CMPW'(count_r);
  assign cnt_last = cnt_x - CMPW'(1);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    do_ins  = 1'b0;
    do_era  = 1'b0;
    rd_ok   = 1'b0;
    ins_idx = pos_x;
    era_idx = pos_x;
    st      = STAT_OK;
    unique case (mode_r)
      MODE_INSERT: begin
        if (full) st = STAT_FULL;
        else if (pos_x > cnt_x) st = STAT_INDEX;
        else do_ins = 1'b1;
      end
      MODE_ERASE: begin
        if (empty) st = STAT_EMPTY;
        else if (pos_x >= cnt_x) st = STAT_INDEX;
        else do_era = 1'b1;
      end
      MODE_READ: begin
        if (pos_x >= cnt_x) st = STAT_INDEX;
        else rd_ok = 1'b1;
      end
      MODE_PUSH_BACK: begin
        if (full) st = STAT_FULL;
        else begin
          do_ins  = 1'b1;
          ins_idx = cnt_x;
        end
      end
      MODE_POP_BACK: begin
        if (empty) st = STAT_EMPTY;
        else begin
          do_era  = 1'b1;
          era_idx = cnt_last;
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) st = STAT_FULL;
        else begin
          do_ins  = 1'b1;
          ins_idx = '0;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) st = STAT_EMPTY;
        else begin
          do_era  = 1'b1;
          era_idx = '0;
        end
      end
      default: begin
        st = STAT_OK;
      end
    endcase
  end

  // a successful read has pos below count, hence below DEPTH
  assign rd_data = slots_r[pos_x[AW-1:0]];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_nb
      if (g > 0) begin : g_lo
        assign lo_nb[g] = slots_r[g-1];
      end else begin : g_lo0
        assign lo_nb[g] = '0;
      end
      if (g < DEPTH - 1) begin : g_up
        assign up_nb[g] = slots_r[g+1];
      end else begin : g_up0
        assign up_nb[g] = '0;
      end
    end
  endgenerate

  // each slot keeps itself, takes its lower or upper neighbor, the new value or zero
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slots_nxt[i] = slots_r[i];
      if (do_ins) begin
        if (CMPW'(i) == ins_idx) slots_nxt[i] = val_r;
        else if (CMPW'(i) > ins_idx && CMPW'(i) <= cnt_x) slots_nxt[i] = lo_nb[i];
      end else if (do_era) begin
        if (CMPW'(i) == cnt_last) slots_nxt[i] = '0;
        else if (CMPW'(i) >= era_idx && CMPW'(i) < cnt_last) slots_nxt[i] = up_nb[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_era) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        slots_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      count_r <= count_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_value_r <= rd_ok ? rd_data : '0;
      count_out_r  <= CNT_W'(count_nxt);
      is_empty_r   <= (count_nxt == '0);
      status_r     <= st;
    end
  end

  assign out_read_value = read_value_r;
  assign out_count      = count_out_r;
  assign out_is_empty   = is_empty_r;
  assign out_status     = status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.execute |=> $stable(count_r))
    else $error("count moved without an executed item");
`endif

endmodule

[hw/rtl/shifting_insert_erase_list.sv]
// result: the result beat is offered once the captured item has been executed in ST_EXEC,
// later while an earlier result still waits in the output register
// order: one item at a time (a capture step, then an execute step in which every slot
// shifts in parallel); a pending result stalls execute, not capture
// reset: synchronous active-low rst_n clears the slot registers and the count at once,
// no clearing pass; the block comes out of reset idle and ready to take an item
module shifting_insert_erase_list import sil_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  sil_in_if.sink    in_ch,
  sil_out_if.source out_ch
);

  sil_cmd_t cmd;

  sil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sil_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_ch.mode),
    .in_position    (in_ch.position),
    .in_value       (in_ch.value),
    .out_read_value (out_ch.read_value),
    .out_count      (out_ch.count),
    .out_is_empty   (out_ch.is_empty),
    .out_status     (out_ch.status)
  );

endmodule

[test/sil_checker.sv]
`timescale 1ns / 1ps
// watches both channels of the list, predicts every result and compares it
module sil_checker import sil_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  sil_in_if    in_mon,
  sil_out_if   out_mon,
  output int   mismatch_total,
  output int   results_owed,
  output int   list_fill
);

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
    status_t                 status;
  } list_result_t;

  logic signed [VAL_W-1:0] slot_q [DEPTH];
  int                      fill;
  list_result_t            owed_q [$];

  function automatic list_result_t predict_list_op(input logic [MODE_W-1:0] mode,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int           at;
    logic         do_ins;
    logic         do_del;
    r.read_value = '0;
    r.status     = STAT_OK;
    do_ins       = 1'b0;
    do_del       = 1'b0;
    at           = 0;
    case (mode)
      MODE_INSERT: begin
        if (fill >= DEPTH) r.status = STAT_FULL;
        else if (int'(pos) > fill) r.status = STAT_INDEX;
        else begin
          do_ins = 1'b1;
          at     = int'(pos);
        end
      end
      MODE_ERASE: begin
        // empty check wins over the index check
        if (fill == 0) r.status = STAT_EMPTY;
        else if (int'(pos) >= fill) r.status = STAT_INDEX;
        else begin
          do_del = 1'b1;
          at     = int'(pos);
        end
      end
      MODE_READ: begin
        if (int'(pos) >= fill) r.status = STAT_INDEX;
        else r.read_value = slot_q[pos];
      end
      MODE_PUSH_BACK: begin
        if (fill >= DEPTH) r.status = STAT_FULL;
        else begin
          do_ins = 1'b1;
          at     = fill;
        end
      end
      MODE_POP_BACK: begin
        if (fill == 0) r.status = STAT_EMPTY;
        else begin
          do_del = 1'b1;
          at     = fill - 1;
        end
      end
      MODE_PUSH_FRONT: begin
        if (fill >= DEPTH) r.status = STAT_FULL;
        else do_ins = 1'b1;
      end
      MODE_POP_FRONT: begin
        if (fill == 0) r.status = STAT_EMPTY;
        else do_del = 1'b1;
      end
      default: ;
    endcase
    if (do_ins) begin
      for (int i = fill; i > at; i--) slot_q[i] = slot_q[i-1];
      slot_q[at] = val;
      fill++;
    end
    if (do_del) begin
      for (int i = at; i + 1 < fill; i++) slot_q[i] = slot_q[i+1];
      fill--;
      // freed slot goes back to zero
      slot_q[fill] = '0;
    end
    r.count    = CNT_W'(fill);
    r.is_empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      foreach (slot_q[i]) slot_q[i] = '0;
      fill = 0;
      owed_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        owed_q.push_back(predict_list_op(in_mon.mode, in_mon.position, in_mon.value));
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t result beat with nothing owed: count %0d status %0d", $time,
                   out_mon.count, out_mon.status);
          mismatch_total++;
        end else begin
          want = owed_q.pop_front();
          if (out_mon.read_value !== want.read_value) begin
            $display("%0t read_value expected %0d actual %0d", $time, want.read_value,
                     out_mon.read_value);
            mismatch_total++;
          end
          if (out_mon.count !== want.count) begin
            $display("%0t count expected %0d actual %0d", $time, want.count, out_mon.count);
            mismatch_total++;
          end
          if (out_mon.is_empty !== want.is_empty) begin
            $display("%0t is_empty expected %0d actual %0d", $time, want.is_empty,
                     out_mon.is_empty);
            mismatch_total++;
          end
          if (out_mon.status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status,
                     out_mon.status);
            mismatch_total++;
          end
        end
      end
    end
    results_owed = owed_q.size();
    list_fill    = fill;
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the shifting insert/erase list
module tb;
  import sil_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIXED  = 2;

  logic clk;
  logic rst_n;
  int   mismatch_total;
  int   results_owed;
  int   list_fill;
  logic src_calm;
  logic sink_calm;
  int   hold_cycles;

  sil_in_if  in_ch ();
  sil_out_if out_ch ();

  shifting_insert_erase_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sil_checker #(.DEPTH(LIST_DEPTH)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed),
    .list_fill      (list_fill)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one input beat, entered and left at a falling edge
  task automatic offer_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic random_op(input int kind);
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0]  p;
    int                r;
    int                cnt;
    cnt = list_fill;
    r   = $urandom_range(0, 99);
    case (kind)
      PH_GROW: begin
        if (r < 10) m = MODE_READ;
        else if (r < 40) m = MODE_INSERT;
        else if (r < 70) m = MODE_PUSH_BACK;
        else m = MODE_PUSH_FRONT;
      end
      PH_SHRINK: begin
        if (r < 10) m = MODE_READ;
        else if (r < 40) m = MODE_ERASE;
        else if (r < 70) m = MODE_POP_BACK;
        else m = MODE_POP_FRONT;
      end
      default: begin
        if (r < 4) m = MODE_UNUSED;
        else m = MODE_W'($urandom_range(0, 6));
      end
    endcase
    // mostly legal indexes, the rest anywhere in the field
    if ($urandom_range(0, 3) == 0) p = POS_W'($urandom_range(0, 63));
    else if (m == MODE_INSERT) p = POS_W'($urandom_range(0, (cnt > 63) ? 63 : cnt));
    else p = (cnt == 0) ? '0 : POS_W'($urandom_range(0, (cnt > 64 ? 64 : cnt) - 1));
    offer_op(m, p, pick_value());
  endtask

  // result side: random wait per beat, plus one long hold-off on request
  initial begin : sink_side
    int wait_n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      wait_n = sink_calm ? 0 : $urandom_range(0, 19);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : limit
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_READ;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    src_calm       = 1'b0;
    sink_calm      = 1'b0;
    hold_cycles    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // refusals on the empty list
    offer_op(MODE_READ, 6'd0, 32'sd0);
    offer_op(MODE_ERASE, 6'd0, 32'sd0);
    offer_op(MODE_POP_BACK, 6'd0, 32'sd0);
    offer_op(MODE_POP_FRONT, 6'd0, 32'sd0);
    offer_op(MODE_INSERT, 6'd1, 32'sd5);
    // build a short list with extreme values
    offer_op(MODE_INSERT, 6'd0, 32'sh7fff_ffff);
    offer_op(MODE_PUSH_BACK, 6'd0, 32'sh8000_0000);
    offer_op(MODE_PUSH_FRONT, 6'd63, -32'sd1);
    offer_op(MODE_INSERT, 6'd3, 32'sd0);
    offer_op(MODE_INSERT, 6'd63, 32'sd1);
    offer_op(MODE_INSERT, 6'd2, 32'sh5555_5555);
    for (int i = 0; i < 5; i++) offer_op(MODE_READ, POS_W'(i), 32'sd0);
    offer_op(MODE_READ, 6'd63, 32'sd0);
    offer_op(MODE_READ, 6'd5, 32'sd0);
    offer_op(MODE_UNUSED, 6'd63, 32'shaaaa_aaaa);
    offer_op(MODE_ERASE, 6'd5, 32'sd0);
    offer_op(MODE_ERASE, 6'd1, 32'sd0);
    offer_op(MODE_POP_BACK, 6'd0, 32'sd0);
    offer_op(MODE_POP_FRONT, 6'd0, 32'sd0);
    offer_op(MODE_ERASE, 6'd0, 32'sd0);
    offer_op(MODE_READ, 6'd0, 32'sd0);

    // grow to full, shrink to empty, mix, in turn
    for (int ph = 0; ph < 7; ph++) begin
      src_calm  = ($urandom_range(0, 2) == 0);
      sink_calm = ($urandom_range(0, 2) == 0);
      if (ph == 3) begin
        // sender keeps offering while the result side holds off
        src_calm    = 1'b1;
        hold_cycles = 300;
      end
      for (int k = 0; k < 80; k++) random_op(ph % 3);
    end

    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[shifting_insert_erase_list.f]
hw/rtl/sil_pkg.sv
hw/rtl/sil_if.sv
hw/rtl/sil_ctrl.sv
hw/rtl/sil_dpath.sv
hw/rtl/shifting_insert_erase_list.sv
test/sil_checker.sv
test/tb.sv
